// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// pcpa_pkg
// Types, codes and helpers of the per-CPU page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pcpa_pkg;

    localparam int PAGE_BYTES      = 4096;
    localparam int PAGE_SHIFT      = 12;
    localparam int PAGE_NUM_MAX_W  = 32 - PAGE_SHIFT;
    localparam int CPU_FIELD_W     = 3;
    localparam int CPU_CODES       = 1 << CPU_FIELD_W;
    localparam int CPU_NUM_MAX_W   = 6;
    localparam int COUNT_W         = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = 1;

    localparam logic [31:0] MEM_START_RESET = 32'h8000_0000;
    localparam logic [31:0] MEM_TOP_RESET   = 32'h8800_0000;

    localparam logic CFG_MEM_START = 1'b0;
    localparam logic CFG_MEM_TOP   = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_ADDR = 2'd1;
    localparam logic [1:0] STATUS_NO_MEM   = 2'd2;

    typedef struct packed {
        logic                   command;
        logic [CPU_FIELD_W-1:0] cpu;
        logic [31:0]            page_address;
    } req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [31:0]            granted_address;
        logic                   stolen;
        logic [CPU_FIELD_W-1:0] source_cpu;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_PUSH,
        OP_BAD
    } op_kind_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [CPU_NUM_MAX_W-1:0]  cpu;
        logic [PAGE_NUM_MAX_W-1:0] page;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_OWN,
        ST_POP,
        ST_SCAN,
        ST_WALK,
        ST_WR_VIC,
        ST_WR_REQ
    } back_state_t;

    function automatic logic [31:0] page_addr(input logic [31:0] start,
                                              input logic [31:0] page);
        logic [32:0] up;
        up = {1'b0, start} + 33'(PAGE_BYTES - 1);
        return {up[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}} + (page << PAGE_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pcpa_front.sv =====
// ----------------------------------------------------------------------------
// pcpa_front
// Takes request items, checks free addresses and turns each item into an op.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_front #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  wire logic          req_valid,
    output logic               req_stall,
    input  pcpa_pkg::req_t     req,
    input  wire logic [31:0]   mem_start,
    input  wire logic [31:0]   mem_top,
    input  wire logic          q_full,
    output logic               q_push,
    output pcpa_pkg::op_t      q_op
);
    import pcpa_pkg::*;

    localparam int CPU_IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    logic [CPU_IW-1:0] cpu_mod_tab [CPU_CODES];
    logic [31:0]       diff;
    logic [31:0]       page_full;
    logic              bad;

    for (genvar g = 0; g < CPU_CODES; g++)
    begin : g_cpu_mod
        assign cpu_mod_tab[g] = CPU_IW'(g % NUM_CPUS);
    end

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    always_comb
    begin
        diff      = req.page_address - mem_start;
        page_full = diff >> PAGE_SHIFT;
        bad       = (req.page_address[PAGE_SHIFT-1:0] != '0)
                 || (req.page_address < mem_start)
                 || (req.page_address >= mem_top)
                 || (page_full >= 32'(NUM_PAGES));
        q_op.cpu  = CPU_NUM_MAX_W'(cpu_mod_tab[req.cpu]);
        q_op.page = diff[31:PAGE_SHIFT];
        if (req.command == CMD_FREE)
        begin
            q_op.kind = bad ? OP_BAD : OP_PUSH;
        end
        else
        begin
            q_op.kind = OP_ALLOC;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcpa_queue.sv =====
// ----------------------------------------------------------------------------
// pcpa_queue
// Short op queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pcpa_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  pcpa_pkg::op_t  push_op,
    output logic           full,
    output logic           valid,
    input  wire logic      pop,
    output pcpa_pkg::op_t  pop_op
);
    import pcpa_pkg::*;

    op_t                ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full   = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign valid  = (count_reg != '0);
    assign pop_op = ent_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pcpa_back.sv =====
// ----------------------------------------------------------------------------
// pcpa_back
// Executes ops: list push, own pop, round-robin steal; owns link and CPU stores.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pcpa_back #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  pcpa_pkg::op_t     q_op,
    output logic              q_pop,
    input  wire logic [31:0]  mem_start,
    output logic              rsp_valid,
    input  wire logic         rsp_stall,
    output pcpa_pkg::rsp_t    rsp
);
    import pcpa_pkg::*;

    localparam int CPU_IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int ENT_W  = PAGE_W + COUNT_W;

    // per-CPU head/count store with reset-cleared valid bits
    logic [ENT_W-1:0]    cpu_mem [NUM_CPUS];
    logic [NUM_CPUS-1:0] cpu_vld_reg;
    logic [ENT_W-1:0]    cpu_rd_reg;
    logic                cpu_rd_vld_reg;
    logic                cpu_rd_en, cpu_wr_en;
    logic [CPU_IW-1:0]   cpu_rd_addr, cpu_wr_addr;
    logic [ENT_W-1:0]    cpu_wr_data;
    logic [PAGE_W-1:0]   head_rd;
    logic [COUNT_W-1:0]  cnt_rd;

    // page link store, contents undefined until written
    logic [PAGE_W-1:0]   link_mem [NUM_PAGES];
    logic [PAGE_W-1:0]   lnk_rd_reg;
    logic                lnk_rd_en, lnk_wr_en;
    logic [PAGE_W-1:0]   lnk_rd_addr, lnk_wr_addr, lnk_wr_data;

    back_state_t         state_reg, state_next;
    logic [CPU_IW-1:0]   op_cpu_reg, op_cpu_next;
    logic                op_push_reg, op_push_next;
    logic [PAGE_W-1:0]   op_page_reg, op_page_next;
    logic [CPU_IW-1:0]   scan_cpu_reg, scan_cpu_next;
    logic [CPU_IW-1:0]   scan_n_reg, scan_n_next;
    logic [COUNT_W-1:0]  walk_left_reg, walk_left_next;
    logic                walk_first_reg, walk_first_next;
    logic [PAGE_W-1:0]   first_reg, first_next;
    logic [PAGE_W-1:0]   req_head_reg, req_head_next;
    logic [PAGE_W-1:0]   vic_head_reg, vic_head_next;
    logic [COUNT_W-1:0]  vic_cnt_reg, vic_cnt_next;
    logic [COUNT_W-1:0]  req_cnt_reg, req_cnt_next;
    logic                rsp_vld_reg;
    rsp_t                rsp_reg, rsp_next;
    logic                out_load, out_free;
    logic [CPU_IW-1:0]   scan_from, scan_step;
    logic [COUNT_W-1:0]  half_cnt;

    assign head_rd   = cpu_rd_vld_reg ? cpu_rd_reg[ENT_W-1:COUNT_W] : '0;
    assign cnt_rd    = cpu_rd_vld_reg ? cpu_rd_reg[COUNT_W-1:0] : '0;
    assign out_free  = !rsp_vld_reg || !rsp_stall;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;
    assign scan_from = (state_reg == ST_RD_OWN) ? op_cpu_reg : scan_cpu_reg;
    assign scan_step = (scan_from == CPU_IW'(NUM_CPUS - 1)) ? '0 : scan_from + 1'b1;
    assign half_cnt  = cnt_rd >> 1;

    always_comb
    begin
        state_next      = state_reg;
        op_cpu_next     = op_cpu_reg;
        op_push_next    = op_push_reg;
        op_page_next    = op_page_reg;
        scan_cpu_next   = scan_cpu_reg;
        scan_n_next     = scan_n_reg;
        walk_left_next  = walk_left_reg;
        walk_first_next = walk_first_reg;
        first_next      = first_reg;
        req_head_next   = req_head_reg;
        vic_head_next   = vic_head_reg;
        vic_cnt_next    = vic_cnt_reg;
        req_cnt_next    = req_cnt_reg;
        q_pop           = 1'b0;
        cpu_rd_en       = 1'b0;
        cpu_rd_addr     = op_cpu_reg;
        cpu_wr_en       = 1'b0;
        cpu_wr_addr     = op_cpu_reg;
        cpu_wr_data     = '0;
        lnk_rd_en       = 1'b0;
        lnk_rd_addr     = head_rd;
        lnk_wr_en       = 1'b0;
        lnk_wr_addr     = op_page_reg;
        lnk_wr_data     = head_rd;
        out_load        = 1'b0;
        rsp_next        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_op.kind == OP_BAD)
                    begin
                        out_load        = 1'b1;
                        rsp_next.status = STATUS_BAD_ADDR;
                    end
                    else
                    begin
                        op_cpu_next  = q_op.cpu[CPU_IW-1:0];
                        op_push_next = (q_op.kind == OP_PUSH);
                        op_page_next = q_op.page[PAGE_W-1:0];
                        cpu_rd_en    = 1'b1;
                        cpu_rd_addr  = q_op.cpu[CPU_IW-1:0];
                        state_next   = ST_RD_OWN;
                    end
                end
            end
            ST_RD_OWN:
            begin
                if (op_push_reg)
                begin
                    lnk_wr_en   = 1'b1;
                    cpu_wr_en   = 1'b1;
                    cpu_wr_data = {op_page_reg,
                                   (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1};
                    out_load    = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (cnt_rd != '0)
                begin
                    lnk_rd_en    = 1'b1;
                    first_next   = head_rd;
                    req_cnt_next = cnt_rd - 1'b1;
                    state_next   = ST_POP;
                end
                else if (NUM_CPUS == 1)
                begin
                    out_load        = 1'b1;
                    rsp_next.status = STATUS_NO_MEM;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cpu_rd_en     = 1'b1;
                    cpu_rd_addr   = scan_step;
                    scan_cpu_next = scan_step;
                    scan_n_next   = CPU_IW'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_POP:
            begin
                cpu_wr_en                = 1'b1;
                cpu_wr_data              = {lnk_rd_reg, req_cnt_reg};
                out_load                 = 1'b1;
                rsp_next.granted_address = page_addr(mem_start, 32'(first_reg));
                rsp_next.source_cpu      = CPU_FIELD_W'(op_cpu_reg);
                state_next               = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (cnt_rd != '0)
                begin
                    // take ceil(n/2): victim keeps floor(n/2)
                    vic_cnt_next    = half_cnt;
                    req_cnt_next    = cnt_rd - half_cnt - 1'b1;
                    walk_left_next  = cnt_rd - half_cnt - 1'b1;
                    walk_first_next = 1'b1;
                    first_next      = head_rd;
                    lnk_rd_en       = 1'b1;
                    state_next      = ST_WALK;
                end
                else if (scan_n_reg == CPU_IW'(NUM_CPUS - 1))
                begin
                    out_load        = 1'b1;
                    rsp_next.status = STATUS_NO_MEM;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cpu_rd_en     = 1'b1;
                    cpu_rd_addr   = scan_step;
                    scan_cpu_next = scan_step;
                    scan_n_next   = scan_n_reg + 1'b1;
                end
            end
            ST_WALK:
            begin
                walk_first_next = 1'b0;
                if (walk_first_reg)
                begin
                    req_head_next = lnk_rd_reg;
                end
                if (walk_left_reg == '0)
                begin
                    vic_head_next = lnk_rd_reg;
                    state_next    = ST_WR_VIC;
                end
                else
                begin
                    lnk_rd_en      = 1'b1;
                    lnk_rd_addr    = lnk_rd_reg;
                    walk_left_next = walk_left_reg - 1'b1;
                end
            end
            ST_WR_VIC:
            begin
                cpu_wr_en   = 1'b1;
                cpu_wr_addr = scan_cpu_reg;
                cpu_wr_data = {vic_head_reg, vic_cnt_reg};
                state_next  = ST_WR_REQ;
            end
            ST_WR_REQ:
            begin
                cpu_wr_en                = 1'b1;
                cpu_wr_data              = {req_head_reg, req_cnt_reg};
                out_load                 = 1'b1;
                rsp_next.granted_address = page_addr(mem_start, 32'(first_reg));
                rsp_next.stolen          = 1'b1;
                rsp_next.source_cpu      = CPU_FIELD_W'(scan_cpu_reg);
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_push_reg    <= 1'b0;
            scan_n_reg     <= '0;
            walk_left_reg  <= '0;
            walk_first_reg <= 1'b0;
            rsp_vld_reg    <= 1'b0;
            cpu_vld_reg    <= '0;
            cpu_rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_push_reg    <= op_push_next;
            scan_n_reg     <= scan_n_next;
            walk_left_reg  <= walk_left_next;
            walk_first_reg <= walk_first_next;
            if (out_load)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_vld_reg <= 1'b0;
            end
            if (cpu_wr_en)
            begin
                cpu_vld_reg[cpu_wr_addr] <= 1'b1;
            end
            if (cpu_rd_en)
            begin
                cpu_rd_vld_reg <= cpu_vld_reg[cpu_rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_cpu_reg   <= op_cpu_next;
        op_page_reg  <= op_page_next;
        scan_cpu_reg <= scan_cpu_next;
        first_reg    <= first_next;
        req_head_reg <= req_head_next;
        vic_head_reg <= vic_head_next;
        vic_cnt_reg  <= vic_cnt_next;
        req_cnt_reg  <= req_cnt_next;
        if (out_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cpu_wr_en)
        begin
            cpu_mem[cpu_wr_addr] <= cpu_wr_data;
        end
        if (cpu_rd_en)
        begin
            cpu_rd_reg <= cpu_mem[cpu_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lnk_wr_en)
        begin
            link_mem[lnk_wr_addr] <= lnk_wr_data;
        end
        if (lnk_rd_en)
        begin
            lnk_rd_reg <= link_mem[lnk_rd_addr];
        end
    end

    `PCPA_ASSERT_IMP(a_pop_out_free, clk, rst_n, q_pop, out_free, "op taken with output busy")
    `PCPA_ASSERT_IMP(a_load_free, clk, rst_n, out_load, out_free, "result overwrites held item")
    `PCPA_ASSERT_IMP(a_victim_other, clk, rst_n, state_reg == ST_WR_REQ, scan_cpu_reg != op_cpu_reg, "steal from own list")
    `PCPA_ASSERT_NXT(a_walk_runs, clk, rst_n, state_reg == ST_WALK && walk_left_reg != '0, state_reg == ST_WALK, "link walk cut short")

endmodule

`default_nettype wire

// ===== rtl/per_cpu_page_allocator_with_steal.sv =====
// ----------------------------------------------------------------------------
// per_cpu_page_allocator_with_steal
// Per-CPU LIFO page free lists with round-robin stealing of half a list.
// ----------------------------------------------------------------------------
//   channel | signals                           | direction
//   req     | req_valid, req_stall, req         | command, cpu, page_address in
//   rsp     | rsp_valid, rsp_stall, rsp         | status, address, stolen, cpu out
//   cfg     | cfg_valid, cfg_ready, cfg_index,  | mem_start / mem_top writes in
//           | cfg_data                          |
//
// A steal scans the other CPUs and makes ceil(n/2) link reads (one link-store
// read a cycle). The queue registers each op, so the back end sees it in the
// cycle after the push; the front runs ahead by two items. Reset clears CPU
// list valid bits at once; no clearing pass, the link store is written before
// read. A stalled result holds the back end, and the front once the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module per_cpu_page_allocator_with_steal #(
    parameter int NUM_CPUS  = 8,
    parameter int NUM_PAGES = 32768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  pcpa_pkg::req_t   req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output pcpa_pkg::rsp_t   rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pcpa_pkg::*;

    logic [31:0] mem_start_reg;
    logic [31:0] mem_top_reg;
    logic        q_full, q_push, q_valid, q_pop;
    op_t         push_op, pop_op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_start_reg <= MEM_START_RESET;
            mem_top_reg   <= MEM_TOP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MEM_START: mem_start_reg <= cfg_data;
                CFG_MEM_TOP:   mem_top_reg   <= cfg_data;
                default:       mem_top_reg   <= mem_top_reg;
            endcase
        end
    end

    pcpa_front #(
        .NUM_CPUS  (NUM_CPUS),
        .NUM_PAGES (NUM_PAGES)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .mem_start (mem_start_reg),
        .mem_top   (mem_top_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    pcpa_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (push_op),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .pop_op  (pop_op)
    );

    pcpa_back #(
        .NUM_CPUS  (NUM_CPUS),
        .NUM_PAGES (NUM_PAGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (pop_op),
        .q_pop     (q_pop),
        .mem_start (mem_start_reg),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the per-CPU page allocator against its own free-list predictor:
// directed frees, pops, steals and out-of-memory cases, then ~1000 random
// items over several mem_start / mem_top windows, with random gaps and stalls.
// ----------------------------------------------------------------------------

module tb;

    import pcpa_pkg::*;

    localparam int LISTS     = 8;
    localparam int PAGES     = 32768;
    localparam int LIMIT     = 600000;
    localparam int MAX_NOTES = 100;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = '0;

    per_cpu_page_allocator_with_steal #(
        .NUM_CPUS  (LISTS),
        .NUM_PAGES (PAGES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // free-list shadow
    logic [14:0] page_link [0:PAGES-1];
    logic [14:0] list_top [0:LISTS-1];
    logic [15:0] list_len [0:LISTS-1];
    logic [31:0] shadow_start = MEM_START_RESET;
    logic [31:0] shadow_top   = MEM_TOP_RESET;

    req_t req_backlog [$];
    rsp_t replies_due [$];

    bit quiet = 1'b0;
    int errors = 0;
    int cycles = 0;
    int n_sent = 0, n_checked = 0;
    int n_own = 0, n_steal = 0, n_oom = 0, n_freed = 0, n_bad = 0;

    function automatic logic [31:0] granted_at(input logic [14:0] pg);
        logic [32:0] base;
        base = ({1'b0, shadow_start} + 33'h0FFF) & ~33'h0FFF;
        return base[31:0] + {5'b0, pg, 12'h000};
    endfunction

    function automatic rsp_t allocator_step(input req_t r);
        rsp_t        e;
        logic [2:0]  c, v;
        logic [31:0] off;
        logic [14:0] pg, last;
        int          take;
        e = '0;
        c = r.cpu;
        if (r.command == CMD_FREE)
        begin
            off = r.page_address - shadow_start;
            if (r.page_address[11:0] != 12'h000 || r.page_address < shadow_start
                || r.page_address >= shadow_top || off[31:27] != 5'b0)
            begin
                e.status = STATUS_BAD_ADDR;
                n_bad++;
            end
            else
            begin
                pg = off[26:12];
                page_link[pg] = list_top[c];
                list_top[c] = pg;
                if (list_len[c] != COUNT_MAX)
                    list_len[c] = list_len[c] + 16'd1;
                n_freed++;
            end
            return e;
        end
        if (list_len[c] != 16'd0)
        begin
            pg = list_top[c];
            list_top[c] = page_link[pg];
            list_len[c] = list_len[c] - 16'd1;
            e.granted_address = granted_at(pg);
            e.source_cpu = c;
            n_own++;
            return e;
        end
        for (int k = 1; k < LISTS; k++)
        begin
            v = c + k[2:0];
            if (list_len[v] == 16'd0)
                continue;
            take = (int'(list_len[v]) + 1) / 2;
            pg = list_top[v];
            last = pg;
            for (int j = 1; j < take; j++)
                last = page_link[last];
            list_top[v] = page_link[last];
            list_len[v] = list_len[v] - 16'(take);
            list_top[c] = page_link[pg];
            list_len[c] = 16'(take - 1);
            e.granted_address = granted_at(pg);
            e.stolen = 1'b1;
            e.source_cpu = v;
            n_steal++;
            return e;
        end
        e.status = STATUS_NO_MEM;
        n_oom++;
        return e;
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
            begin
                replies_due.push_back(allocator_step(req));
                n_sent++;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_backlog.size() != 0 && (quiet || $urandom_range(0, 99) >= 28))
                begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_NOTES)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        end
    endtask

    // reply monitor
    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_NOTES)
                        $display("%0t: unexpected reply, expected none, actual %h",
                                 $time, rsp);
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("granted_address", want.granted_address,
                                rsp.granted_address);
                    check_field("stolen", want.stolen, rsp.stolen);
                    check_field("source_cpu", want.source_cpu, rsp.source_cpu);
                    n_checked++;
                end
            end
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 28);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, replies_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic add_item(input logic cmd, input logic [2:0] cpu, input logic [31:0] addr);
        req_t r;
        r.command = cmd;
        r.cpu = cpu;
        r.page_address = addr;
        req_backlog.push_back(r);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MEM_START)
            shadow_start = val;
        else
            shadow_top = val;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || replies_due.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    // mostly good frees into a small page pool, allocs from any cpu, some noise
    task automatic add_traffic(input int n);
        logic [32:0] base, span;
        logic [31:0] k;
        int          alloc_pct, hot;
        base = ({1'b0, shadow_start} + 33'h0FFF) & ~33'h0FFF;
        span = (base < {1'b0, shadow_top}) ? ({1'b0, shadow_top} - base + 33'h0FFF) >> 12 : '0;
        if (span > PAGES)
            span = PAGES;
        alloc_pct = 40;
        hot = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                alloc_pct = $urandom_range(20, 70);
                hot = $urandom_range(0, LISTS - 1);
            end
            if ($urandom_range(0, 99) < 12 || ($urandom_range(0, 99) >= alloc_pct && span == 0))
                add_item($urandom_range(0, 1), $urandom_range(0, 7), $urandom);
            else if ($urandom_range(0, 99) < alloc_pct)
                add_item(CMD_ALLOC, $urandom_range(0, 7), $urandom);
            else
            begin
                if ($urandom_range(0, 7) == 0 || span < 96)
                    k = $urandom_range(0, span - 1);
                else
                    k = $urandom_range(0, 95);
                add_item(CMD_FREE,
                         ($urandom_range(0, 3) != 0) ? 3'(hot + $urandom_range(0, 1))
                                                     : 3'($urandom_range(0, 7)),
                         base[31:0] + (k << 12));
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < LISTS; i++)
        begin
            list_top[i] = '0;
            list_len[i] = '0;
        end

        // reset window: own pops, steals with wrap, bad frees, double free
        add_item(CMD_ALLOC, 3'd0, 32'h0000_0000);
        add_item(CMD_FREE,  3'd0, 32'h8000_0000);
        add_item(CMD_FREE,  3'd0, 32'h8000_1000);
        add_item(CMD_FREE,  3'd0, 32'h8000_2000);
        add_item(CMD_FREE,  3'd0, 32'h8000_3000);
        add_item(CMD_FREE,  3'd0, 32'h8000_4000);
        add_item(CMD_FREE,  3'd0, 32'h87FF_F000);
        add_item(CMD_FREE,  3'd2, 32'h8000_0800);
        add_item(CMD_FREE,  3'd2, 32'h7FFF_F000);
        add_item(CMD_FREE,  3'd2, 32'h8800_0000);
        add_item(CMD_FREE,  3'd2, 32'hFFFF_F000);
        add_item(CMD_ALLOC, 3'd0, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd5, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd5, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd0, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd0, 32'h0000_0000);
        add_item(CMD_FREE,  3'd1, 32'h8001_0000);
        add_item(CMD_ALLOC, 3'd7, 32'hFFFF_FFFF);
        add_item(CMD_FREE,  3'd4, 32'h8002_0000);
        add_item(CMD_FREE,  3'd4, 32'h8002_0000);
        add_item(CMD_ALLOC, 3'd4, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd4, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd6, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd3, 32'h0000_0000);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        drain();

        // whole address space, no gaps or stalls
        quiet = 1'b1;
        write_reg(CFG_MEM_START, 32'h0000_0000);
        write_reg(CFG_MEM_TOP,   32'hFFFF_FFFF);
        add_item(CMD_FREE,  3'd3, 32'h0800_0000);
        add_item(CMD_FREE,  3'd3, 32'h07FF_F000);
        add_item(CMD_FREE,  3'd3, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd3, 32'h0000_0000);
        add_item(CMD_ALLOC, 3'd3, 32'h0000_0000);
        add_traffic(300);
        drain();
        quiet = 1'b0;

        // unaligned start and top
        write_reg(CFG_MEM_START, 32'h4000_0123);
        write_reg(CFG_MEM_TOP,   32'h4003_F800);
        add_traffic(350);
        drain();

        // start rounds up past 2^32: grants wrap, every free is bad
        write_reg(CFG_MEM_START, 32'hFFFF_F001);
        write_reg(CFG_MEM_TOP,   32'hFFFF_FFFF);
        add_traffic(80);
        drain();

        write_reg(CFG_MEM_START, MEM_START_RESET);
        write_reg(CFG_MEM_TOP,   32'h0000_0000);
        add_traffic(40);
        drain();

        write_reg(CFG_MEM_TOP, MEM_TOP_RESET);
        add_traffic(250);
        drain();

        $display("sent %0d items, checked %0d replies over six address windows",
                 n_sent, n_checked);
        $display("own pops %0d, steals %0d, out of memory %0d, frees %0d, bad frees %0d",
                 n_own, n_steal, n_oom, n_freed, n_bad);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
